[rtl/c2i_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c2i_pkg
// Shared types and codes of the col2im accumulator: request and response
// words, item kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package c2i_pkg;

   localparam int SUM_WIDTH   = 40;
   localparam int VALUE_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 7;

   // item kinds
   localparam logic KIND_ACCUMULATE = 1'b0;
   localparam logic KIND_READ       = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PAD_ROWS      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PAD_COLS      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IMAGE_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KERNEL_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KERNEL_WIDTH  = 3'd5;

   typedef struct packed {
      logic                           kind;
      logic [3:0]                     kernel_row;
      logic [3:0]                     kernel_col;
      logic [6:0]                     out_row;
      logic [6:0]                     out_col;
      logic signed [VALUE_WIDTH-1:0]  col_value;
      logic [5:0]                     read_row;
      logic [5:0]                     read_col;
   } req_word_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] image_sum;
      logic                        in_range;
      logic                        saturated;
   } rsp_word_type;

endpackage
`default_nettype wire

[rtl/col2im_accumulate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// col2im_accumulate
// Stride-1 col2im for one channel plane: column elements are added into a
// 40-bit saturating accumulator store; read items return and clear a sum.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   start, busy, req_word               start & !busy
//  response  rsp_strobe, rsp_word                one-cycle strobe
//  config    csr_valid, csr_ready, csr_index,    valid & ready
//            csr_data
//
//  Each item passes through the writeback stage: the accumulator RAM is read
//  at the accept edge and written back from the stage registers, so busy is
//  high for one cycle after an accept. The response shows in the cycle after
//  the writeback. After reset a clearing pass zeroes the RAM, one entry a cycle,
//  through all MAX_HEIGHT*MAX_WIDTH entries (4096 by default); busy is high
//  meanwhile. Config writes are always taken. The response side cannot stall.
// ----------------------------------------------------------------------------
module col2im_accumulate #(
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_KERNEL = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire c2i_pkg::req_word_type                   req_word,
   output      logic                                    rsp_strobe,
   output      c2i_pkg::rsp_word_type                   rsp_word,
   input  wire logic                                    csr_valid,
   output      logic                                    csr_ready,
   input  wire logic [c2i_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  wire logic [c2i_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = c2i_pkg::SUM_WIDTH;

   localparam logic [11:0] MAX_H = 12'(MAX_HEIGHT);
   localparam logic [11:0] MAX_W = 12'(MAX_WIDTH);
   localparam logic [11:0] MAX_K = 12'(MAX_KERNEL);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // configuration registers
   logic [3:0] pad_rows_ff, pad_cols_ff;
   logic [6:0] image_height_ff, image_width_ff;
   logic [4:0] kernel_height_ff, kernel_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_rows_ff      <= '0;
         pad_cols_ff      <= '0;
         image_height_ff  <= 7'd64;
         image_width_ff   <= 7'd64;
         kernel_height_ff <= 5'd3;
         kernel_width_ff  <= 5'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            c2i_pkg::CSR_PAD_ROWS:      pad_rows_ff      <= csr_data[3:0];
            c2i_pkg::CSR_PAD_COLS:      pad_cols_ff      <= csr_data[3:0];
            c2i_pkg::CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
            c2i_pkg::CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data;
            c2i_pkg::CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_data[4:0];
            c2i_pkg::CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // target decode of the incoming word
   logic          accept;
   logic [11:0]   eh, ew, kh, kw;
   logic [11:0]   row_sum, col_sum, pad_r, pad_c;
   logic [11:0]   acc_row, acc_col, row_sel, col_sel;
   logic          acc_hit, read_hit, hit;
   logic [AW-1:0] addr;

   assign accept = start && !busy;

   always_comb begin
      eh = (12'(image_height_ff) > MAX_H) ? MAX_H : 12'(image_height_ff);
      ew = (12'(image_width_ff) > MAX_W) ? MAX_W : 12'(image_width_ff);
      kh = (12'(kernel_height_ff) > MAX_K) ? MAX_K : 12'(kernel_height_ff);
      kw = (12'(kernel_width_ff) > MAX_K) ? MAX_K : 12'(kernel_width_ff);
      pad_r   = 12'(pad_rows_ff);
      pad_c   = 12'(pad_cols_ff);
      row_sum = 12'(req_word.out_row) + 12'(req_word.kernel_row);
      col_sum = 12'(req_word.out_col) + 12'(req_word.kernel_col);
      acc_row = row_sum - pad_r;
      acc_col = col_sum - pad_c;
      // out_row < eh + 2*pad - kh + 1, kept unsigned
      acc_hit = (12'(req_word.kernel_row) < kh) && (12'(req_word.kernel_col) < kw)
              && (12'(req_word.out_row) + kh <= eh + (pad_r << 1))
              && (12'(req_word.out_col) + kw <= ew + (pad_c << 1))
              && (row_sum >= pad_r) && (acc_row < eh)
              && (col_sum >= pad_c) && (acc_col < ew);
      read_hit = (12'(req_word.read_row) < eh) && (12'(req_word.read_col) < ew);
      if (req_word.kind == c2i_pkg::KIND_READ) begin
         hit     = read_hit;
         row_sel = 12'(req_word.read_row);
         col_sel = 12'(req_word.read_col);
      end else begin
         hit     = acc_hit;
         row_sel = acc_row;
         col_sel = acc_col;
      end
      addr = AW'(32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_sel));
   end

   // writeback stage
   logic                          stage_valid_ff;
   logic                          stage_kind_ff, stage_hit_ff;
   logic [AW-1:0]                 stage_addr_ff;
   logic signed [c2i_pkg::VALUE_WIDTH-1:0] stage_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_kind_ff  <= req_word.kind;
         stage_hit_ff   <= hit;
         stage_addr_ff  <= addr;
         stage_value_ff <= req_word.col_value;
      end
   end

   assign busy = clearing_ff || stage_valid_ff;

   // accumulator RAM
   logic [SW-1:0] acc_mem [DEPTH];
   logic [SW-1:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data;
   logic [SW:0]   sum_wide;
   logic [SW-1:0] sum_sat;
   logic          sat;

   always_comb begin
      sum_wide = {rd_data_ff[SW-1], rd_data_ff}
               + (SW+1)'(stage_value_ff);
      sat      = sum_wide[SW] != sum_wide[SW-1];
      if (!sat) begin
         sum_sat = sum_wide[SW-1:0];
      end else if (sum_wide[SW]) begin
         sum_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(SW-1){1'b1}}};
      end
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = stage_valid_ff && stage_hit_ff;
         wr_addr = stage_addr_ff;
         wr_data = (stage_kind_ff == c2i_pkg::KIND_READ) ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
      if (accept && hit) begin
         rd_data_ff <= acc_mem[addr];
      end
   end

   // response register
   logic                  rsp_strobe_ff;
   c2i_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   always_comb begin
      rsp_word_in.image_sum = '0;
      rsp_word_in.in_range  = stage_hit_ff;
      rsp_word_in.saturated = 1'b0;
      if (stage_hit_ff) begin
         if (stage_kind_ff == c2i_pkg::KIND_READ) begin
            rsp_word_in.image_sum = rd_data_ff;
         end else begin
            rsp_word_in.saturated = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire

[dv/col2im_accumulate_tb.sv]
// ----------------------------------------------------------------------------
// col2im_accumulate_tb
// Self-checking bench for the stride-1 col2im accumulator. A directed table
// covers reset settings, range limits and error paths. Random phases follow
// under shuffled register settings and sender gaps. Two phases drive one pixel
// into positive and negative saturation. Every response word is compared with
// a directed item's typed answer or a behavioral copy of the accumulator plane.
// ----------------------------------------------------------------------------
module col2im_accumulate_tb;
   import c2i_pkg::*;

   localparam int MAX_HEIGHT = 64;
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_KERNEL = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 66;
   localparam int SAT_PER_PHASE = 280;
   localparam int NUM_PLAN = 40;
   localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   typedef enum logic {PLAN_ITEM, PLAN_CSR} plan_kind_type;

   typedef struct {
      plan_kind_type              what;
      req_word_type               word;
      logic [CSR_IDX_WIDTH-1:0]   csr_idx;
      logic [CSR_DATA_WIDTH-1:0]  csr_val;
      bit                         typed;
      rsp_word_type               typed_rsp;
   } plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_strobe;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // behavioral copy of the accumulator plane and its settings
   logic signed [SUM_WIDTH-1:0] plane_sums [MAX_HEIGHT*MAX_WIDTH];
   logic [3:0] cfg_pad_rows = 4'd0;
   logic [3:0] cfg_pad_cols = 4'd0;
   logic [6:0] cfg_img_h = 7'd64;
   logic [6:0] cfg_img_w = 7'd64;
   logic [4:0] cfg_ker_h = 5'd3;
   logic [4:0] cfg_ker_w = 5'd3;

   rsp_word_type results_due [$];
   plan_type directed_plan [NUM_PLAN];
   int mismatches = 0;
   int cycle_count = 0;
   int gap_pct = 0;

   col2im_accumulate #(
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_KERNEL(MAX_KERNEL)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_size(input int v, input int m);
      return (v < m) ? v : m;
   endfunction

   // accumulate or read-and-clear against the plane copy
   function automatic rsp_word_type col2im_predict(input req_word_type w);
      int eh, ew, kh, kw, pr, pc, out_h, out_w;
      int kr, kc, orow, ocol, r, c, idx;
      longint s;
      rsp_word_type res;
      eh = eff_size(int'(cfg_img_h), MAX_HEIGHT);
      ew = eff_size(int'(cfg_img_w), MAX_WIDTH);
      kh = eff_size(int'(cfg_ker_h), MAX_KERNEL);
      kw = eff_size(int'(cfg_ker_w), MAX_KERNEL);
      pr = int'(cfg_pad_rows);
      pc = int'(cfg_pad_cols);
      res = '0;
      if (w.kind == KIND_READ) begin
         r = int'(w.read_row);
         c = int'(w.read_col);
         if (r < eh && c < ew) begin
            idx = r * MAX_WIDTH + c;
            res.image_sum = plane_sums[idx];
            res.in_range = 1'b1;
            plane_sums[idx] = '0;
         end
      end else begin
         kr = int'(w.kernel_row);
         kc = int'(w.kernel_col);
         orow = int'(w.out_row);
         ocol = int'(w.out_col);
         out_h = eh + 2 * pr - kh + 1;
         out_w = ew + 2 * pc - kw + 1;
         r = orow + kr - pr;
         c = ocol + kc - pc;
         if (kr < kh && kc < kw && orow < out_h && ocol < out_w &&
             r >= 0 && r < eh && c >= 0 && c < ew) begin
            idx = r * MAX_WIDTH + c;
            s = longint'($signed(plane_sums[idx])) + longint'($signed(w.col_value));
            if (s > SUM_HI) begin
               s = SUM_HI;
               res.saturated = 1'b1;
            end
            if (s < SUM_LO) begin
               s = SUM_LO;
               res.saturated = 1'b1;
            end
            plane_sums[idx] = s[SUM_WIDTH-1:0];
            res.in_range = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic plan_type plan_acc(input int kr, input int kc, input int orow,
                                         input int ocol, input logic [31:0] v,
                                         input int typed, input logic rng);
      plan_type p;
      p.what = PLAN_ITEM;
      p.word = '0;
      p.word.kind = KIND_ACCUMULATE;
      p.word.kernel_row = 4'(kr);
      p.word.kernel_col = 4'(kc);
      p.word.out_row = 7'(orow);
      p.word.out_col = 7'(ocol);
      p.word.col_value = v;
      p.csr_idx = '0;
      p.csr_val = '0;
      p.typed = (typed != 0);
      p.typed_rsp = '0;
      p.typed_rsp.in_range = rng;
      return p;
   endfunction

   function automatic plan_type plan_read(input int r, input int c, input int typed,
                                          input logic signed [SUM_WIDTH-1:0] sum,
                                          input logic rng);
      plan_type p;
      p.what = PLAN_ITEM;
      p.word = '0;
      p.word.kind = KIND_READ;
      p.word.read_row = 6'(r);
      p.word.read_col = 6'(c);
      p.csr_idx = '0;
      p.csr_val = '0;
      p.typed = (typed != 0);
      p.typed_rsp = '0;
      p.typed_rsp.image_sum = sum;
      p.typed_rsp.in_range = rng;
      return p;
   endfunction

   function automatic plan_type plan_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                                         input logic [CSR_DATA_WIDTH-1:0] v);
      plan_type p;
      p.what = PLAN_CSR;
      p.word = '0;
      p.csr_idx = idx;
      p.csr_val = v;
      p.typed = 1'b0;
      p.typed_rsp = '0;
      return p;
   endfunction

   function automatic req_word_type noise_word();
      req_word_type w;
      w.kind = 1'($urandom_range(1));
      w.kernel_row = 4'($urandom_range(15));
      w.kernel_col = 4'($urandom_range(15));
      w.out_row = 7'($urandom_range(127));
      w.out_col = 7'($urandom_range(127));
      w.col_value = $urandom;
      w.read_row = 6'($urandom_range(63));
      w.read_col = 6'($urandom_range(63));
      return w;
   endfunction

   // mostly well-formed column elements and in-range reads, some raw noise
   function automatic req_word_type random_item();
      req_word_type w;
      int eh, ew, kh, kw, out_h, out_w, pick;
      eh = eff_size(int'(cfg_img_h), MAX_HEIGHT);
      ew = eff_size(int'(cfg_img_w), MAX_WIDTH);
      kh = eff_size(int'(cfg_ker_h), MAX_KERNEL);
      kw = eff_size(int'(cfg_ker_w), MAX_KERNEL);
      out_h = eh + 2 * int'(cfg_pad_rows) - kh + 1;
      out_w = ew + 2 * int'(cfg_pad_cols) - kw + 1;
      w = noise_word();
      pick = $urandom_range(99);
      if (pick >= 15 && pick < 35) begin
         w.kind = KIND_READ;
         if (eh > 0 && $urandom_range(4) != 0) w.read_row = 6'($urandom_range(eh - 1));
         if (ew > 0 && $urandom_range(4) != 0) w.read_col = 6'($urandom_range(ew - 1));
      end else if (pick >= 35) begin
         w.kind = KIND_ACCUMULATE;
         if (kh > 0) w.kernel_row = 4'($urandom_range(kh - 1));
         if (kw > 0) w.kernel_col = 4'($urandom_range(kw - 1));
         if (out_h > 0) w.out_row = 7'($urandom_range(out_h - 1));
         if (out_w > 0) w.out_col = 7'($urandom_range(out_w - 1));
         case ($urandom_range(9))
            0: w.col_value = {16'h7FFF, 16'($urandom)};
            1: w.col_value = {16'h8000, 16'($urandom)};
            2: w.col_value = 32'($urandom_range(511)) - 32'd256;
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_pad();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 7'($urandom_range(3));
      if (p < 65) return 7'd15;
      if (p < 75) return 7'd0;
      return 7'($urandom_range(15));
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_size();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 7'($urandom_range(8, 1));
      if (p < 70) return 7'd64;
      if (p < 78) return 7'd0;
      if (p < 85) return 7'd127;
      return 7'($urandom_range(127, 1));
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_kernel();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 7'($urandom_range(4, 1));
      if (p < 70) return 7'd16;
      if (p < 77) return 7'd0;
      if (p < 84) return 7'd31;
      return 7'($urandom_range(31));
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PAD_ROWS:      cfg_pad_rows = val[3:0];
         CSR_PAD_COLS:      cfg_pad_cols = val[3:0];
         CSR_IMAGE_HEIGHT:  cfg_img_h = val[6:0];
         CSR_IMAGE_WIDTH:   cfg_img_w = val[6:0];
         CSR_KERNEL_HEIGHT: cfg_ker_h = val[4:0];
         CSR_KERNEL_WIDTH:  cfg_ker_w = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // the caller drives start again, or settle drops it, at the falling edge this returns on,
   // while busy still blocks the next accept
   task automatic issue(input req_word_type w, input bit typed,
                        input rsp_word_type typed_rsp);
      rsp_word_type pred;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
      pred = col2im_predict(w);
      results_due.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic shuffle_settings();
      write_csr(CSR_PAD_ROWS, pick_pad());
      write_csr(CSR_PAD_COLS, pick_pad());
      write_csr(CSR_IMAGE_HEIGHT, pick_size());
      write_csr(CSR_IMAGE_WIDTH, pick_size());
      write_csr(CSR_KERNEL_HEIGHT, pick_kernel());
      write_csr(CSR_KERNEL_WIDTH, pick_kernel());
      // unused indexes must not disturb anything
      if ($urandom_range(1) == 1)
         write_csr(3'($urandom_range(7, 6)), 7'($urandom_range(127)));
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word: sum %0d in_range %0b saturated %0b",
                        $realtime, rsp_word.image_sum, rsp_word.in_range,
                        rsp_word.saturated);
         end else begin
            exp_word = results_due.pop_front();
            if (rsp_word.image_sum !== exp_word.image_sum ||
                rsp_word.in_range !== exp_word.in_range ||
                rsp_word.saturated !== exp_word.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: word mismatch: exp sum %0d in_range %0b ",
                            "saturated %0b, got sum %0d in_range %0b saturated %0b"},
                           $realtime, exp_word.image_sum, exp_word.in_range,
                           exp_word.saturated, rsp_word.image_sum,
                           rsp_word.in_range, rsp_word.saturated);
            end
         end
      end
   end

   initial begin
      req_word_type w;
      rsp_word_type no_rsp;
      int ph, n;
      no_rsp = '0;
      foreach (plane_sums[i]) plane_sums[i] = '0;

      directed_plan = '{
         // reset settings: 64x64 image, 3x3 kernel, no padding
         plan_read(0, 0, 1, 40'sd0, 1'b1),
         plan_read(63, 63, 1, 40'sd0, 1'b1),
         plan_acc(0, 0, 0, 0, 32'h7FFF_FFFF, 1, 1'b1),
         plan_acc(2, 2, 61, 61, 32'h8000_0000, 1, 1'b1),
         plan_acc(3, 0, 0, 0, 32'h1, 1, 1'b0),
         plan_acc(0, 3, 0, 0, 32'h1, 1, 1'b0),
         plan_acc(0, 0, 62, 0, 32'h1, 1, 1'b0),
         plan_acc(15, 15, 127, 127, 32'hFFFF_FFFF, 1, 1'b0),
         plan_read(0, 0, 1, 40'sh00_7FFF_FFFF, 1'b1),
         plan_read(0, 0, 1, 40'sd0, 1'b1),
         plan_read(63, 63, 1, 40'shFF_8000_0000, 1'b1),
         plan_csr(3'd6, 7'd1),
         plan_csr(3'd7, 7'd1),
         plan_read(63, 63, 1, 40'sd0, 1'b1),
         // max padding around a single pixel, largest kernel
         plan_csr(CSR_PAD_ROWS, 7'd15),
         plan_csr(CSR_PAD_COLS, 7'd15),
         plan_csr(CSR_IMAGE_HEIGHT, 7'd1),
         plan_csr(CSR_IMAGE_WIDTH, 7'd1),
         plan_csr(CSR_KERNEL_HEIGHT, 7'd16),
         plan_csr(CSR_KERNEL_WIDTH, 7'd16),
         plan_acc(15, 15, 0, 0, 32'h1, 1, 1'b1),
         plan_acc(0, 0, 0, 0, 32'h1, 1, 1'b0),
         plan_acc(15, 15, 15, 15, 32'h1, 1, 1'b0),
         plan_acc(15, 15, 16, 0, 32'h1, 1, 1'b0),
         plan_acc(15, 15, 0, 0, 32'hFFFF_0000, 0, 1'b0),
         plan_read(1, 0, 1, 40'sd0, 1'b0),
         plan_read(0, 0, 0, 40'sd0, 1'b0),
         // zero height makes every position invalid
         plan_csr(CSR_PAD_ROWS, 7'd0),
         plan_csr(CSR_PAD_COLS, 7'd0),
         plan_csr(CSR_IMAGE_HEIGHT, 7'd0),
         plan_csr(CSR_IMAGE_WIDTH, 7'd127),
         plan_csr(CSR_KERNEL_HEIGHT, 7'd0),
         plan_csr(CSR_KERNEL_WIDTH, 7'd31),
         plan_acc(0, 0, 0, 0, 32'h1, 1, 1'b0),
         plan_read(0, 0, 1, 40'sd0, 1'b0),
         // oversized settings clip to the maximum sizes
         plan_csr(CSR_IMAGE_HEIGHT, 7'd127),
         plan_csr(CSR_KERNEL_HEIGHT, 7'd31),
         plan_acc(15, 15, 48, 48, 32'h8000_0000, 1, 1'b1),
         plan_acc(15, 15, 49, 48, 32'h1, 1, 1'b0),
         plan_read(63, 63, 1, 40'shFF_8000_0000, 1'b1)
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].what == PLAN_CSR) begin
            settle();
            write_csr(directed_plan[i].csr_idx, directed_plan[i].csr_val);
         end else begin
            issue(directed_plan[i].word, directed_plan[i].typed,
                  directed_plan[i].typed_rsp);
         end
      end

      for (ph = 0; ph < 4; ph++) begin
         settle();
         shuffle_settings();
         gap_pct = (ph == 1) ? 67 : (ph == 3) ? 23 : 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(63) == 0) settle();
            issue(random_item(), 1'b0, no_rsp);
         end
      end

      // one pixel, 1x1 kernel: push it to the top limit, clear, then the bottom
      settle();
      write_csr(CSR_PAD_ROWS, 7'd0);
      write_csr(CSR_PAD_COLS, 7'd0);
      write_csr(CSR_IMAGE_HEIGHT, 7'd1);
      write_csr(CSR_IMAGE_WIDTH, 7'd1);
      write_csr(CSR_KERNEL_HEIGHT, 7'd1);
      write_csr(CSR_KERNEL_WIDTH, 7'd1);
      for (ph = 0; ph < 2; ph++) begin
         gap_pct = (ph == 0) ? 67 : 23;
         for (n = 0; n < SAT_PER_PHASE; n++) begin
            if ($urandom_range(19) == 0) begin
               // stray word that neither lands nor clears the pixel
               w = noise_word();
               if (w.kind == KIND_READ) w.read_row[0] = 1'b1;
               else w.kernel_row[0] = 1'b1;
            end else begin
               w = '0;
               w.kind = KIND_ACCUMULATE;
               w.col_value = {(ph == 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            end
            issue(w, 1'b0, no_rsp);
         end
         w = '0;
         w.kind = KIND_READ;
         issue(w, 1'b0, no_rsp);
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/c2i_pkg.sv
rtl/col2im_accumulate.sv
dv/col2im_accumulate_tb.sv
